>>> hw/rtl/u8u16_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_BIG_ENDIAN      = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODEPOINT_LIMIT = 1'd1;

  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [15:0] HI_SURR   = 16'hD800;
  localparam logic [5:0]  LO_SURR   = 6'b110111;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_string;
    logic       last_of_string;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
    logic        limit_reached;
    logic [15:0] units_total;
    logic [15:0] bytes_total;
  } out_beat_t;

  typedef struct packed {
    logic [20:0] partial_code;
    logic [1:0]  bytes_pending;
    logic [15:0] unit_count;
    logic [15:0] byte_count;
    logic [15:0] point_count;
    logic        stopped;
  } str_state_t;

  typedef struct packed {
    logic      emit;
    logic      pair;
    out_beat_t beat0;
    out_beat_t beat1;
  } dec_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/u8u16_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module u8u16_decode (
  input  u8u16_pkg::in_beat_t   beat_i,
  input  u8u16_pkg::str_state_t state_i,
  input  logic                  big_endian_i,
  input  logic [15:0]           limit_i,
  output u8u16_pkg::str_state_t state_nxt_o,
  output u8u16_pkg::dec_res_t   res_o
);
  import u8u16_pkg::*;

  str_state_t  s;
  logic [7:0]  b;
  logic [20:0] pc;
  logic [1:0]  pend;
  logic [20:0] cp;
  logic [20:0] c;
  logic [15:0] pcount;
  logic [15:0] bcount;
  logic        hit;
  logic        swap;
  logic [15:0] u0;
  logic [15:0] u1;
  logic        pair;

  always_comb begin
    s    = beat_i.first_of_string ? '0 : state_i;
    b    = beat_i.data_byte;
    pc   = s.partial_code;
    pend = s.bytes_pending;
    bcount = s.byte_count + 16'd1;

    if (s.bytes_pending == 2'd0) begin
      case (b) inside
        [8'h00:8'h7F]: begin
          pc   = {13'd0, b};
          pend = 2'd0;
        end
        [8'hF0:8'hFF]: begin
          pc   = {18'd0, b[2:0]};
          pend = 2'd3;
        end
        [8'hE0:8'hEF]: begin
          pc   = {17'd0, b[3:0]};
          pend = 2'd2;
        end
        [8'hC0:8'hDF]: begin
          pc   = {16'd0, b[4:0]};
          pend = 2'd1;
        end
        default: begin
          pc   = '0;
          pend = 2'd0;
        end
      endcase
    end else begin
      pc   = {s.partial_code[14:0], b[5:0]};
      pend = s.bytes_pending - 2'd1;
    end

    if (beat_i.last_of_string) begin
      case (pend)
        2'd1:    pc = {pc[14:0], 6'd0};
        2'd2:    pc = {pc[8:0], 12'd0};
        2'd3:    pc = {pc[2:0], 18'd0};
        default: pc = pc;
      endcase
      pend = 2'd0;
    end

    cp     = pc;
    c      = cp - SUPP_BASE;
    pcount = s.point_count + 16'd1;
    hit    = (limit_i != 16'd0) && (pcount == limit_i);
    swap   = !(big_endian_i || (limit_i == 16'd1));
    pair   = (cp[20:16] != 5'd0);
    u0     = pair ? ({5'd0, c[20:10]} | HI_SURR) : cp[15:0];
    u1     = {LO_SURR, c[9:0]};
    if (swap) begin
      u0 = {u0[7:0], u0[15:8]};
      u1 = {u1[7:0], u1[15:8]};
    end

    state_nxt_o = s;
    res_o       = '0;
    res_o.beat0.code_unit     = u0;
    res_o.beat0.last_unit     = !pair;
    res_o.beat0.limit_reached = hit;
    res_o.beat0.units_total   = s.unit_count + 16'd1;
    res_o.beat0.bytes_total   = bcount;
    res_o.beat1.code_unit     = u1;
    res_o.beat1.last_unit     = 1'b1;
    res_o.beat1.limit_reached = hit;
    res_o.beat1.units_total   = s.unit_count + 16'd2;
    res_o.beat1.bytes_total   = bcount;

    if (!s.stopped) begin
      state_nxt_o.byte_count = bcount;
      if (pend != 2'd0) begin
        state_nxt_o.partial_code  = pc;
        state_nxt_o.bytes_pending = pend;
      end else begin
        state_nxt_o.partial_code  = '0;
        state_nxt_o.bytes_pending = 2'd0;
        state_nxt_o.point_count   = pcount;
        state_nxt_o.stopped       = hit;
        state_nxt_o.unit_count    = pair ? s.unit_count + 16'd2 : s.unit_count + 16'd1;
        res_o.emit = 1'b1;
        res_o.pair = pair;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder.
// Input channel (in_valid/in_ready/in_data): one UTF-8 byte per beat, with
// first_of_string clearing all string state and last_of_string flushing an
// unfinished sequence with zero bits.
// Result channel (out_valid/out_ready/out_data): one UTF-16 unit per beat;
// a code point above 0xFFFF gives two beats back to back, the second
// carrying last_unit. Bytes inside a sequence give no beat.
// Configuration: cfg_we/cfg_index/cfg_wdata, index 0 big_endian, index 1
// codepoint_limit; writes take effect on the next cycle.
// A byte accepted into the input register is decoded combinationally, and
// its first unit is then registered in the output register for out_data.
// Throughput: one byte per cycle while out_ready stays high; a surrogate
// pair holds the input until its second unit moves to the output register.
// Once the limit is reached, bytes are still taken but give no beat until
// the next first_of_string.
// Reset (rst_n low at a clock edge) empties the input, output and pair
// registers, clears the string state, sets big_endian=1, codepoint_limit=0.
// When the receiver stalls, the output register holds and the input side
// stops once the input register is also full.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_transcoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  u8u16_pkg::in_beat_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output u8u16_pkg::out_beat_t                out_data,
  input  logic                                cfg_we,
  input  logic [u8u16_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [u8u16_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import u8u16_pkg::*;

  logic        big_endian_r;
  logic [15:0] limit_r;
  logic        inq_valid_r;
  in_beat_t    inq_data_r;
  str_state_t  state_r;
  str_state_t  state_nxt;
  dec_res_t    dec;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_beat_t   out_data_r;
  out_beat_t   out_data_nxt;
  logic        sec_valid_r;
  logic        sec_valid_nxt;
  out_beat_t   sec_data_r;
  out_beat_t   sec_data_nxt;
  logic        adv;

  assign adv       = inq_valid_r && !sec_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !inq_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  u8u16_decode u_decode (
    .beat_i       (inq_data_r),
    .state_i      (state_r),
    .big_endian_i (big_endian_r),
    .limit_i      (limit_r),
    .state_nxt_o  (state_nxt),
    .res_o        (dec)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sec_valid_nxt = sec_valid_r;
    sec_data_nxt  = sec_data_r;
    if (adv && dec.emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = dec.beat0;
      sec_valid_nxt = dec.pair;
      sec_data_nxt  = dec.beat1;
    end else if (out_valid_r && out_ready) begin
      if (sec_valid_r) begin
        out_data_nxt  = sec_data_r;
        sec_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b1;
      limit_r      <= '0;
      inq_valid_r  <= 1'b0;
      state_r      <= '0;
      out_valid_r  <= 1'b0;
      sec_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BIG_ENDIAN:      big_endian_r <= cfg_wdata[0];
          CFG_CODEPOINT_LIMIT: limit_r      <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_ready) begin
        inq_valid_r <= in_valid;
      end
      if (adv) begin
        state_r <= state_nxt;
      end
      out_valid_r <= out_valid_nxt;
      sec_valid_r <= sec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      inq_data_r <= in_data;
    end
    out_data_r <= out_data_nxt;
    sec_data_r <= sec_data_nxt;
  end

endmodule

`default_nettype wire

>>> hw/rtl/u8u16_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module u8u16_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  u8u16_pkg::out_beat_t out_data
);
  import u8u16_pkg::*;

  logic mid_pair;
  assign mid_pair = out_valid && out_ready && !out_data.last_unit;

  // second unit of a pair follows at once with the next unit count
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pair |=> out_valid && (out_data.units_total == $past(out_data.units_total) + 16'd1))
    else $error("surrogate pair second unit missing or miscounted");

  a_pair_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pair |=> out_data.bytes_total == $past(out_data.bytes_total))
    else $error("byte total differs within a pair");

  a_pair_limit: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pair |=> out_data.limit_reached == $past(out_data.limit_reached))
    else $error("limit flag differs within a pair");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
